// File: rtl/core/rmst_pkg.sv
// Shared constants, codes and port structs for the range minimum segment tree.
// Used by rmst_node_store and by the top level range_min_segment_tree.
package rmst_pkg;

	// Tree geometry: the leaves sit at nodes LEAVES to 2*LEAVES-1, and node 1 is the root.
	localparam int LEAVES  = 1024;
	localparam int LEAF_AW = $clog2(LEAVES);
	localparam int NODES   = 2 * LEAVES;
	localparam int NODE_AW = LEAF_AW + 1;
	// Walk bounds of a query reach 2*LEAVES, so they need one more bit than a node address.
	localparam int WALK_W  = NODE_AW + 1;
	localparam int CNT_W   = 11;

	localparam int VAL_W = 32;
	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

	localparam logic [CNT_W-1:0]  COUNT_RESET = CNT_W'(LEAVES);
	localparam logic [CNT_W-1:0]  COUNT_CAP   = CNT_W'(LEAVES);
	localparam logic [NODE_AW-1:0] NODE_ROOT  = NODE_AW'(1);

	// Item kinds carried in tuser.
	localparam logic ACT_UPDATE = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

	// Result status codes.
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	// Write and read requests to the node store.
	typedef struct packed {
		logic                    en;
		logic [NODE_AW-1:0]      addr;
		logic signed [VAL_W-1:0] data;
	} rmst_wr_t;

	typedef struct packed {
		logic               en;
		logic [NODE_AW-1:0] addr;
	} rmst_rd_t;

endpackage

// File: rtl/core/rmst_node_store.sv
// Node store of the segment tree: one synchronous memory with a registered read port.
// Runs a clearing pass after reset that fills every node with the largest value.
// Depends on rmst_pkg.
module rmst_node_store
	import rmst_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  rmst_wr_t                wr,
	input  rmst_rd_t                rd,
	output logic signed [VAL_W-1:0] rd_data,
	output logic                    clear_busy
);

	logic signed [VAL_W-1:0] mem [NODES];
	logic [NODE_AW-1:0]      clr_addr_q;
	logic                    clr_busy_q;
	logic signed [VAL_W-1:0] rd_data_q;

	// Clearing pass: one node per cycle from address zero to the last node.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + NODE_AW'(1);
			if (clr_addr_q == {NODE_AW{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Single write port; the clearing pass owns it until it finishes.
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= VAL_MAX;
		end else if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_q <= mem[rd.addr];
		end
	end

	assign rd_data    = rd_data_q;
	assign clear_busy = clr_busy_q;

endmodule

// File: rtl/core/range_min_segment_tree.sv
// Range minimum segment tree over 2048 nodes: point updates and inclusive range queries.
// An update writes the leaf and then one parent per level; a query walks states QA and QB
// per level over eleven levels with one node read port; flagged items and empty ranges
// go straight to the result. One item is in work at a time; the next beat is taken
// the cycle after a result is loaded. Reset: the count returns to 1024 and a clearing
// pass fills every node first.
module range_min_segment_tree
	import rmst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration channel: element_count.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data,
	// Input items.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: update_index [9:0], new_value [41:10], range_low [51:42],
	// range_high [61:52], zero fill [63:62].
	input  logic [63:0] s_axis_tdata,
	// tuser: action [0].
	input  logic [0:0]  s_axis_tuser,
	// Result items.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: min_value [31:0].
	output logic [31:0] m_axis_tdata,
	// tuser: status [0].
	output logic [0:0]  m_axis_tuser
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ULEAF = 3'd1;
	localparam logic [2:0] ST_UUP   = 3'd2;
	localparam logic [2:0] ST_QA    = 3'd3;
	localparam logic [2:0] ST_QB    = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]              state_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_eff;

	// Fields of the incoming beat.
	logic                    in_action;
	logic [LEAF_AW-1:0]      in_index;
	logic signed [VAL_W-1:0] in_value;
	logic [LEAF_AW-1:0]      in_low;
	logic [LEAF_AW-1:0]      in_high;
	logic                    in_flag;

	// Item in work.
	logic                    action_q;
	logic                    status_q;
	logic [NODE_AW-1:0]      p_q;
	logic signed [VAL_W-1:0] cur_q;
	logic [WALK_W-1:0]       a_q;
	logic [WALK_W-1:0]       b_q;
	logic signed [VAL_W-1:0] acc_q;
	logic                    rd_pend_q;

	// Output register.
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] out_value_q;
	logic                    out_status_q;

	// Node store ports.
	rmst_wr_t                wr;
	rmst_rd_t                rd;
	logic signed [VAL_W-1:0] rd_data;
	logic                    clear_busy;

	logic                    in_fire;
	logic                    out_load;
	logic signed [VAL_W-1:0] parent_min;
	logic [NODE_AW-1:0]      p_up;
	logic [WALK_W-1:0]       b_dec;
	logic [WALK_W-1:0]       b_use;

	rmst_node_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.rd         (rd),
		.rd_data    (rd_data),
		.clear_busy (clear_busy)
	);

	// Unpack the input beat.
	assign in_action = s_axis_tuser[0];
	assign in_index  = s_axis_tdata[9:0];
	assign in_value  = $signed(s_axis_tdata[41:10]);
	assign in_low    = s_axis_tdata[51:42];
	assign in_high   = s_axis_tdata[61:52];

	// A count above the capacity acts as the capacity.
	assign count_eff = (count_q > COUNT_CAP) ? COUNT_CAP : count_q;

	always_comb begin
		if (in_action == ACT_UPDATE) begin
			in_flag = {1'b0, in_index} >= count_eff;
		end else begin
			in_flag = ({1'b0, in_low} >= count_eff) || ({1'b0, in_high} >= count_eff);
		end
	end

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE) && !clear_busy;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	// Helpers for the update climb and the query walk.
	assign parent_min = (cur_q < rd_data) ? cur_q : rd_data;
	assign p_up       = p_q >> 1;
	assign b_dec      = b_q - WALK_W'(1);
	assign b_use      = b_q[0] ? b_dec : b_q;

	// Memory requests. The climb reads only siblings off the path it writes, and a
	// query only reads, so a read never meets a write to the same node.
	always_comb begin
		wr      = '0;
		rd      = '0;
		wr.data = cur_q;
		unique case (state_q)
			ST_ULEAF: begin
				wr.en   = 1'b1;
				wr.addr = p_q;
				rd.en   = 1'b1;
				rd.addr = p_q ^ NODE_AW'(1);
			end
			ST_UUP: begin
				wr.en   = 1'b1;
				wr.addr = p_up;
				wr.data = parent_min;
				rd.en   = (p_up != NODE_ROOT);
				rd.addr = p_up ^ NODE_AW'(1);
			end
			ST_QA: begin
				rd.en   = (a_q < b_q) && a_q[0];
				rd.addr = a_q[NODE_AW-1:0];
			end
			ST_QB: begin
				rd.en   = b_q[0];
				rd.addr = b_dec[NODE_AW-1:0];
			end
			default: begin
			end
		endcase
	end

	// Element count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_data;
		end
	end

	// Sequencer for updates and queries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_pend_q <= 1'b0;
		end else begin
			rd_pend_q <= rd.en && ((state_q == ST_QA) || (state_q == ST_QB));
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (in_flag) begin
							state_q <= ST_DONE;
						end else if (in_action == ACT_UPDATE) begin
							state_q <= ST_ULEAF;
						end else if (in_low > in_high) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_QA;
						end
					end
				end
				ST_ULEAF: state_q <= ST_UUP;
				ST_UUP: begin
					if (p_up == NODE_ROOT) begin
						state_q <= ST_DONE;
					end
				end
				ST_QA: begin
					if (a_q >= b_q) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_QB;
					end
				end
				ST_QB:   state_q <= ST_QA;
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item registers: captured on acceptance, then stepped by the sequencer.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			action_q <= in_action;
			status_q <= in_flag ? STATUS_RANGE : STATUS_OK;
			p_q      <= {1'b1, in_index};
			cur_q    <= in_value;
			a_q      <= {2'b01, in_low};
			b_q      <= {2'b00, in_high} + WALK_W'(LEAVES + 1);
		end else begin
			unique case (state_q)
				ST_UUP: begin
					p_q   <= p_up;
					cur_q <= parent_min;
				end
				ST_QA: begin
					if ((a_q < b_q) && a_q[0]) begin
						a_q <= a_q + WALK_W'(1);
					end
				end
				ST_QB: begin
					a_q <= a_q >> 1;
					b_q <= b_use >> 1;
				end
				default: begin
				end
			endcase
		end
	end

	// Query accumulator: folds in each node read in the cycle after it is issued.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			acc_q <= VAL_MAX;
		end else if (rd_pend_q && (rd_data < acc_q)) begin
			acc_q <= rd_data;
		end
	end

	// Output register: holds a result while the next item is taken in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= status_q;
			if ((action_q == ACT_QUERY) && (status_q == STATUS_OK)) begin
				out_value_q <= acc_q;
			end else begin
				out_value_q <= '0;
			end
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_value_q;
	assign m_axis_tuser[0] = out_status_q;

endmodule
